>>> design/sorted_mode_table_closest_match_unit_defines.svh
// Assertion macros shared by the checker of the display-mode table.
`ifndef SORTED_MODE_TABLE_CLOSEST_MATCH_UNIT_DEFINES_SVH
`define SORTED_MODE_TABLE_CLOSEST_MATCH_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SMTCM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SMTCM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/smtcm_pkg.sv
// Types, constants and codes of the sorted display-mode table.
package smtcm_pkg;

    localparam int MAX_MODES = 64;
    localparam int IDX_W     = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
    localparam int CNT_W     = $clog2(MAX_MODES + 1);
    localparam int MODE_W    = 45;
    localparam int SCORE_W   = 28;

    localparam logic [11:0] ORIGINAL_RATE_RST = 12'd960;
    localparam logic [6:0]  MIN_DEPTH_RST     = 7'd16;
    localparam logic [12:0] MIN_WIDTH_RST     = 13'd320;
    localparam logic [12:0] MIN_HEIGHT_RST    = 13'd240;

    typedef enum logic [1:0] {
        FUNC_INSERT,
        FUNC_FIND,
        FUNC_READ,
        FUNC_CLEAR
    } t_func;

    typedef enum logic [2:0] {
        STATUS_OK,
        STATUS_FILTERED,
        STATUS_DUPLICATE,
        STATUS_FULL,
        STATUS_EMPTY,
        STATUS_BAD_INDEX
    } t_status;

    typedef enum logic [1:0] {
        CFG_ORIGINAL_RATE,
        CFG_MIN_DEPTH,
        CFG_MIN_WIDTH,
        CFG_MIN_HEIGHT
    } t_cfg_reg;

    typedef struct packed {
        logic [12:0] width;
        logic [12:0] height;
        logic [6:0]  depth;
        logic [11:0] rate;
    } t_mode;

    typedef struct packed {
        t_func       func;
        logic [12:0] mode_width;
        logic [12:0] mode_height;
        logic [6:0]  mode_depth;
        logic [11:0] mode_rate;
        logic [5:0]  mode_index;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [5:0]  hit_index;
        logic [12:0] hit_width;
        logic [12:0] hit_height;
        logic [6:0]  hit_depth;
        logic [11:0] hit_rate;
        logic [27:0] best_score;
        logic [6:0]  entry_count;
    } t_out_item;

    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] idx;
    } t_score_tag;

    typedef struct packed {
        logic               vld;
        logic [IDX_W-1:0]   idx;
        logic [SCORE_W-1:0] score;
        t_mode              entry;
    } t_score_res;

endpackage

>>> design/sorted_mode_table_closest_match_unit.sv
// A table of up to 64 display modes kept sorted by height, width, depth and the distance of the
// rate from the original rate, with insert, closest-match search, read by index and clear.
// One item is worked on at a time, and the block stalls its input until the result has been
// handed to the output register. The table lives in a memory with one read and one write port,
// so every walk over it moves one entry per cycle. An insert first scans the table for a
// duplicate and the insertion point (a duplicate ends the scan early), then moves the entries
// above the insertion point up one place and writes the new entry; a closest search reads
// every entry into a three-stage distance pipeline; a read by index issues one read and waits
// for its data; clear, a filtered insert, an empty search or a bad index go straight to the
// result. The result then moves to the output register, where it may wait under stall while
// the next item is accepted.
module sorted_mode_table_closest_match_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  smtcm_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output smtcm_pkg::t_out_item o_out_item,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [12:0]          i_cfg_data
);

    localparam int IW = smtcm_pkg::IDX_W;
    localparam int CW = smtcm_pkg::CNT_W;
    localparam int SW = smtcm_pkg::SCORE_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_SCAN,
        ST_SHIFT,
        ST_FIND,
        ST_RD_ISSUE,
        ST_RD_WAIT,
        ST_DONE
    } t_state;

    t_state               r_state;
    smtcm_pkg::t_mode     r_q;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_ptr;
    logic [CW-1:0]        r_pos;
    logic                 r_rd_vld;
    logic [IW-1:0]        r_rd_idx;
    logic                 r_best_vld;
    logic [IW-1:0]        r_best_idx;
    logic [SW-1:0]        r_best_score;
    smtcm_pkg::t_mode     r_best_entry;
    smtcm_pkg::t_out_item r_res;
    smtcm_pkg::t_out_item r_out_item;
    logic                 r_out_vld;
    logic [11:0]          r_original_rate;
    logic [6:0]           r_min_depth;
    logic [12:0]          r_min_width;
    logic [12:0]          r_min_height;

    smtcm_pkg::t_mode      c_rd;
    logic [smtcm_pkg::MODE_W-1:0] c_rdata;
    logic                  c_issue;
    logic                  c_we;
    logic [IW-1:0]         c_waddr;
    smtcm_pkg::t_mode      c_wdata;
    logic [IW-1:0]         c_raddr;
    logic [11:0]           c_dist_q;
    logic [11:0]           c_dist_e;
    logic                  c_tie;
    logic                  c_less;
    logic                  c_filtered;
    logic                  c_bad_index;
    smtcm_pkg::t_out_item  c_init_res;
    smtcm_pkg::t_score_tag c_tag;
    smtcm_pkg::t_score_res c_sc;
    logic                  c_sc_busy;

    function automatic logic [11:0] f_rate_dist(input logic [11:0] r, input logic [11:0] o);
        return (r >= o) ? r - o : o - r;
    endfunction

    assign c_rd = c_rdata;

    always_comb begin
        c_issue = 1'b0;
        c_raddr = IW'(r_ptr);
        case (r_state)
            ST_INS_SCAN, ST_FIND: begin
                c_issue = (r_ptr < r_count);
            end
            ST_SHIFT: begin
                c_issue = (r_ptr > r_pos);
                c_raddr = IW'(r_ptr - CW'(1));
            end
            default: begin
                c_issue = 1'b0;
            end
        endcase
    end

    always_comb begin
        c_we    = 1'b0;
        c_waddr = IW'(r_pos);
        c_wdata = r_q;
        if (r_state == ST_SHIFT) begin
            if (r_rd_vld) begin
                c_we    = 1'b1;
                c_waddr = IW'(CW'(r_rd_idx) + CW'(1));
                c_wdata = c_rd;
            end else if (r_ptr == r_pos) begin
                c_we = 1'b1;
            end
        end
    end

    always_comb begin
        c_dist_q = f_rate_dist(r_q.rate, r_original_rate);
        c_dist_e = f_rate_dist(c_rd.rate, r_original_rate);
        c_tie    = (r_q.height == c_rd.height) && (r_q.width == c_rd.width) &&
                   (r_q.depth == c_rd.depth) && (c_dist_q == c_dist_e);
        c_less   = (r_q.height < c_rd.height) ||
                   ((r_q.height == c_rd.height) &&
                    ((r_q.width < c_rd.width) ||
                     ((r_q.width == c_rd.width) &&
                      ((r_q.depth < c_rd.depth) ||
                       ((r_q.depth == c_rd.depth) && (c_dist_q < c_dist_e))))));
        c_filtered = (i_in_item.mode_depth < r_min_depth) ||
                     (i_in_item.mode_width < r_min_width) ||
                     (i_in_item.mode_height < r_min_height);
        c_bad_index = (16'(i_in_item.mode_index) >= 16'(r_count));
        c_tag.vld  = (r_state == ST_FIND) && r_rd_vld;
        c_tag.idx  = r_rd_idx;
    end

    always_comb begin
        c_init_res             = '0;
        c_init_res.entry_count = 7'(r_count);
        case (i_in_item.func)
            smtcm_pkg::FUNC_INSERT: begin
                if (c_filtered) begin
                    c_init_res.status = smtcm_pkg::STATUS_FILTERED;
                end
            end
            smtcm_pkg::FUNC_FIND: begin
                if (r_count == '0) begin
                    c_init_res.status = smtcm_pkg::STATUS_EMPTY;
                end
            end
            smtcm_pkg::FUNC_READ: begin
                if (c_bad_index) begin
                    c_init_res.status = smtcm_pkg::STATUS_BAD_INDEX;
                end
            end
            default: begin
                c_init_res.entry_count = '0;
            end
        endcase
    end

    smtcm_ram #(
        .WIDTH (smtcm_pkg::MODE_W),
        .DEPTH (smtcm_pkg::MAX_MODES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    smtcm_score u_score (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (c_tag),
        .i_entry (c_rd),
        .i_query (r_q),
        .o_res   (c_sc),
        .o_busy  (c_sc_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_count         <= '0;
            r_rd_vld        <= 1'b0;
            r_best_vld      <= 1'b0;
            r_out_vld       <= 1'b0;
            r_original_rate <= smtcm_pkg::ORIGINAL_RATE_RST;
            r_min_depth     <= smtcm_pkg::MIN_DEPTH_RST;
            r_min_width     <= smtcm_pkg::MIN_WIDTH_RST;
            r_min_height    <= smtcm_pkg::MIN_HEIGHT_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    smtcm_pkg::CFG_ORIGINAL_RATE: r_original_rate <= i_cfg_data[11:0];
                    smtcm_pkg::CFG_MIN_DEPTH:     r_min_depth     <= i_cfg_data[6:0];
                    smtcm_pkg::CFG_MIN_WIDTH:     r_min_width     <= i_cfg_data;
                    smtcm_pkg::CFG_MIN_HEIGHT:    r_min_height    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_out_vld && !i_out_stall && (r_state != ST_DONE)) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_q.width  <= i_in_item.mode_width;
                        r_q.height <= i_in_item.mode_height;
                        r_q.depth  <= i_in_item.mode_depth;
                        r_q.rate   <= i_in_item.mode_rate;
                        r_rd_vld   <= 1'b0;
                        r_best_vld <= 1'b0;
                        r_ptr      <= (i_in_item.func == smtcm_pkg::FUNC_READ) ?
                                      CW'(i_in_item.mode_index) : '0;
                        r_pos      <= r_count;
                        r_res      <= c_init_res;
                        case (i_in_item.func)
                            smtcm_pkg::FUNC_INSERT: begin
                                if (c_filtered) begin
                                    r_state <= ST_DONE;
                                end else begin
                                    r_state <= ST_INS_SCAN;
                                end
                            end
                            smtcm_pkg::FUNC_FIND: begin
                                if (r_count == '0) begin
                                    r_state <= ST_DONE;
                                end else begin
                                    r_state <= ST_FIND;
                                end
                            end
                            smtcm_pkg::FUNC_READ: begin
                                if (c_bad_index) begin
                                    r_state <= ST_DONE;
                                end else begin
                                    r_state <= ST_RD_ISSUE;
                                end
                            end
                            default: begin
                                r_count <= '0;
                                r_state <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_INS_SCAN: begin
                    r_rd_vld <= c_issue;
                    r_rd_idx <= IW'(r_ptr);
                    if (c_issue) begin
                        r_ptr <= r_ptr + CW'(1);
                    end
                    if (r_rd_vld && c_tie) begin
                        r_res.status     <= smtcm_pkg::STATUS_DUPLICATE;
                        r_res.hit_index  <= 6'(r_rd_idx);
                        r_res.hit_width  <= c_rd.width;
                        r_res.hit_height <= c_rd.height;
                        r_res.hit_depth  <= c_rd.depth;
                        r_res.hit_rate   <= c_rd.rate;
                        r_state          <= ST_DONE;
                    end else begin
                        if (r_rd_vld && c_less && (r_pos == r_count)) begin
                            r_pos <= CW'(r_rd_idx);
                        end
                        if (!r_rd_vld && !c_issue) begin
                            if (r_count >= CW'(smtcm_pkg::MAX_MODES)) begin
                                r_res.status <= smtcm_pkg::STATUS_FULL;
                                r_state      <= ST_DONE;
                            end else begin
                                r_ptr   <= r_count;
                                r_state <= ST_SHIFT;
                            end
                        end
                    end
                end
                ST_SHIFT: begin
                    r_rd_vld <= c_issue;
                    r_rd_idx <= IW'(r_ptr - CW'(1));
                    if (c_issue) begin
                        r_ptr <= r_ptr - CW'(1);
                    end
                    if (!r_rd_vld && !c_issue) begin
                        r_count           <= r_count + CW'(1);
                        r_res.status      <= smtcm_pkg::STATUS_OK;
                        r_res.hit_index   <= 6'(r_pos);
                        r_res.hit_width   <= r_q.width;
                        r_res.hit_height  <= r_q.height;
                        r_res.hit_depth   <= r_q.depth;
                        r_res.hit_rate    <= r_q.rate;
                        r_res.entry_count <= 7'(r_count + CW'(1));
                        r_state           <= ST_DONE;
                    end
                end
                ST_FIND: begin
                    r_rd_vld <= c_issue;
                    r_rd_idx <= IW'(r_ptr);
                    if (c_issue) begin
                        r_ptr <= r_ptr + CW'(1);
                    end
                    if (c_sc.vld && (!r_best_vld || (c_sc.score < r_best_score))) begin
                        r_best_vld   <= 1'b1;
                        r_best_idx   <= c_sc.idx;
                        r_best_score <= c_sc.score;
                        r_best_entry <= c_sc.entry;
                    end
                    if (!r_rd_vld && !c_issue && !c_sc_busy) begin
                        r_res.status     <= smtcm_pkg::STATUS_OK;
                        r_res.hit_index  <= 6'(r_best_idx);
                        r_res.hit_width  <= r_best_entry.width;
                        r_res.hit_height <= r_best_entry.height;
                        r_res.hit_depth  <= r_best_entry.depth;
                        r_res.hit_rate   <= r_best_entry.rate;
                        r_res.best_score <= r_best_score;
                        r_state          <= ST_DONE;
                    end
                end
                ST_RD_ISSUE: begin
                    r_state <= ST_RD_WAIT;
                end
                ST_RD_WAIT: begin
                    r_res.status     <= smtcm_pkg::STATUS_OK;
                    r_res.hit_index  <= 6'(r_ptr);
                    r_res.hit_width  <= c_rd.width;
                    r_res.hit_height <= c_rd.height;
                    r_res.hit_depth  <= c_rd.depth;
                    r_res.hit_rate   <= c_rd.rate;
                    r_state          <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_out_vld || !i_out_stall) begin
                        r_out_item <= r_res;
                        r_out_vld  <= 1'b1;
                        r_state    <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

endmodule

>>> design/smtcm_ram.sv
// Simple dual-port table memory with one write port and a registered read port.
module smtcm_ram #(
    parameter int WIDTH = 45,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/smtcm_score.sv
// Three-stage pipeline that computes the squared distance of a stored mode to a query.
module smtcm_score (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  smtcm_pkg::t_score_tag i_tag,
    input  smtcm_pkg::t_mode      i_entry,
    input  smtcm_pkg::t_mode      i_query,
    output smtcm_pkg::t_score_res o_res,
    output logic                  o_busy
);

    localparam int IW = smtcm_pkg::IDX_W;
    localparam int SW = smtcm_pkg::SCORE_W;

    smtcm_pkg::t_score_tag r_s1_tag;
    smtcm_pkg::t_score_tag r_s2_tag;
    smtcm_pkg::t_mode      r_s1_entry;
    smtcm_pkg::t_mode      r_s2_entry;
    smtcm_pkg::t_score_res r_s3;

    logic [12:0] r_dw;
    logic [12:0] r_dh;
    logic [6:0]  r_dd;
    logic [11:0] r_dr;
    logic [25:0] r_sw;
    logic [25:0] r_sh;
    logic [13:0] r_sd;
    logic [15:0] r_sr;

    logic [25:0] c_sw;
    logic [25:0] c_sh;
    logic [13:0] c_sd;
    logic [23:0] c_sr;
    logic [SW:0] c_sum;

    always_comb begin
        c_sw  = r_dw * r_dw;
        c_sh  = r_dh * r_dh;
        c_sd  = r_dd * r_dd;
        c_sr  = r_dr * r_dr;
        c_sum = (SW + 1)'(r_sw) + (SW + 1)'(r_sh) + (SW + 1)'(r_sd) + (SW + 1)'(r_sr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_tag.vld <= 1'b0;
            r_s2_tag.vld <= 1'b0;
            r_s3.vld     <= 1'b0;
        end else begin
            r_s1_tag <= i_tag;
            r_s2_tag <= r_s1_tag;
            r_s3.vld <= r_s2_tag.vld;
        end
        r_s1_entry <= i_entry;
        r_dw <= (i_entry.width >= i_query.width) ? i_entry.width - i_query.width
                                                 : i_query.width - i_entry.width;
        r_dh <= (i_entry.height >= i_query.height) ? i_entry.height - i_query.height
                                                   : i_query.height - i_entry.height;
        r_dd <= (i_entry.depth >= i_query.depth) ? i_entry.depth - i_query.depth
                                                 : i_query.depth - i_entry.depth;
        r_dr <= (i_entry.rate >= i_query.rate) ? i_entry.rate - i_query.rate
                                               : i_query.rate - i_entry.rate;
        r_s2_entry <= r_s1_entry;
        r_sw <= c_sw;
        r_sh <= c_sh;
        r_sd <= c_sd;
        r_sr <= (i_query.rate != 12'd0) ? c_sr[23:8] : 16'd0;
        r_s3.idx   <= IW'(r_s2_tag.idx);
        r_s3.entry <= r_s2_entry;
        r_s3.score <= c_sum[SW] ? {SW{1'b1}} : c_sum[SW-1:0];
    end

    assign o_res  = r_s3;
    assign o_busy = r_s1_tag.vld | r_s2_tag.vld | r_s3.vld;

endmodule

>>> design/smtcm_checker.sv
// Port-level checks of the display-mode table, bound to its top level.
`include "sorted_mode_table_closest_match_unit_defines.svh"

module smtcm_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input smtcm_pkg::t_in_item  i_in_item,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input smtcm_pkg::t_out_item o_out_item,
    input logic                 i_cfg_we,
    input logic [1:0]           i_cfg_index,
    input logic [12:0]          i_cfg_data
);

    // An accepted item is worked on alone, so the input must stall in the next cycle.
    `SMTCM_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "input not stalled after an accepted item")

    // Failed operations carry no entry and no score.
    `SMTCM_ASSERT_SAME(a_fail_zero_fields, o_out_valid && (o_out_item.status == smtcm_pkg::STATUS_FILTERED || o_out_item.status == smtcm_pkg::STATUS_FULL || o_out_item.status == smtcm_pkg::STATUS_EMPTY || o_out_item.status == smtcm_pkg::STATUS_BAD_INDEX), o_out_item.hit_index == 6'd0 && o_out_item.hit_width == 13'd0 && o_out_item.hit_height == 13'd0 && o_out_item.hit_depth == 7'd0 && o_out_item.hit_rate == 12'd0 && o_out_item.best_score == 28'd0, "failed operation reports entry fields")

    // The table never reports more entries than it can hold.
    `SMTCM_ASSERT_SAME(a_count_bound, o_out_valid, 32'(o_out_item.entry_count) <= smtcm_pkg::MAX_MODES, "entry count above table size")

    // A stalled result stays in place.
    `SMTCM_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item), "stalled result changed")

endmodule

bind sorted_mode_table_closest_match_unit smtcm_checker u_smtcm_checker (.*);
